// File: hw/rtl/rtp_interleaved_packetizer_assert.svh
// assertion macros used by the packetizer top level
`ifndef RTP_INTERLEAVED_PACKETIZER_ASSERT_SVH
`define RTP_INTERLEAVED_PACKETIZER_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define RTPILP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtp packetizer assertion failed");

// next-cycle implication, checked on clk outside reset
`define RTPILP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtp packetizer assertion failed");

`endif

// File: hw/rtl/rtpilp_pkg.sv
// types and constants shared by the rtp interleaved packetizer
package rtpilp_pkg;

    // largest rtp payload per packet
    localparam int unsigned MAX_PAYLOAD = 1400;
    localparam int unsigned SIZE_W      = 22;
    localparam int unsigned PKT_W       = 11;
    localparam logic [SIZE_W-1:0] MAX_PAYLOAD_SIZE = SIZE_W'(MAX_PAYLOAD);
    localparam logic [PKT_W-1:0]  MAX_PAYLOAD_PKT  = PKT_W'(MAX_PAYLOAD);

    // job queue between front and back, depth a power of two
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // fu-a nal type and fixed length offsets
    localparam logic [4:0]  FU_A_TYPE      = 5'd28;
    localparam logic [15:0] LEN_OFS_VIDEO  = 16'd12;
    localparam logic [15:0] LEN_OFS_FU     = 16'd14;
    localparam logic [15:0] LEN_OFS_AUDIO  = 16'd16;

    // configuration register indexes
    localparam logic [2:0] REG_VERSION   = 3'd0;
    localparam logic [2:0] REG_PADDING   = 3'd1;
    localparam logic [2:0] REG_EXTENSION = 3'd2;
    localparam logic [2:0] REG_CSRC      = 3'd3;
    localparam logic [2:0] REG_PTYPE     = 3'd4;
    localparam logic [2:0] REG_SSRC      = 3'd5;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              unit_first;
        logic [SIZE_W-1:0] unit_size;
        logic              unit_kind;
        logic              frame_end;
        logic [7:0]        channel;
        logic [31:0]       timestamp;
    } unit_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       unit_done;
        logic       run_last;
    } result_word_t;

    typedef struct packed {
        logic [1:0]  rtp_version;
        logic        padding_bit;
        logic        extension_bit;
        logic [3:0]  csrc_count;
        logic [6:0]  payload_type;
        logic [31:0] source_id;
    } cfg_t;

    // which header, if any, goes in front of the data byte
    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_VIDEO,
        HDR_AUDIO,
        HDR_FU
    } hdr_kind_t;

    // one classified input byte for the back end
    typedef struct packed {
        hdr_kind_t   hdr;
        logic [15:0] len;
        logic        marker;
        logic [15:0] seq;
        logic [7:0]  channel;
        logic [31:0] timestamp;
        logic [7:0]  extra0;
        logic [7:0]  extra1;
        logic [7:0]  data_byte;
        logic        packet_end;
        logic        unit_done;
    } job_t;

endpackage

// File: hw/rtl/rtpilp_front.sv
// front end: takes unit bytes, tracks unit and fragment state, builds jobs
module rtpilp_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  rtpilp_pkg::unit_word_t  word,
    output logic                    job_valid,
    output rtpilp_pkg::job_t        job
);
    import rtpilp_pkg::*;

    logic [15:0]       seq_reg, seq_next;
    logic [SIZE_W-1:0] left_reg, left_next;
    logic [PKT_W-1:0]  pkt_left_reg, pkt_left_next;
    logic [7:0]        nal_reg, nal_next;
    logic              pending_reg, pending_next;
    logic [7:0]        ch_reg, ch_next;
    logic [31:0]       ts_reg, ts_next;
    logic              fe_reg, fe_next;
    logic              frag_reg, frag_next;

    logic [SIZE_W-1:0] size_eff;
    logic              starts_frag;
    logic              new_pkt;
    logic              last_frag;
    logic [PKT_W-1:0]  frag_len;
    logic [PKT_W-1:0]  pkt_cur;

    // classify the byte and work out the next unit state
    always_comb
    begin
        seq_next      = seq_reg;
        left_next     = left_reg;
        pkt_left_next = pkt_left_reg;
        nal_next      = nal_reg;
        pending_next  = pending_reg;
        ch_next       = ch_reg;
        ts_next       = ts_reg;
        fe_next       = fe_reg;
        frag_next     = frag_reg;

        size_eff    = (word.unit_size == '0) ? SIZE_W'(1) : word.unit_size;
        starts_frag = !word.unit_kind && (size_eff > MAX_PAYLOAD_SIZE);
        new_pkt     = frag_reg && (pkt_left_reg == '0);
        last_frag   = (left_reg <= MAX_PAYLOAD_SIZE);
        frag_len    = last_frag ? left_reg[PKT_W-1:0] : MAX_PAYLOAD_PKT;
        pkt_cur     = pkt_left_reg;

        job_valid      = 1'b0;
        job.hdr        = HDR_NONE;
        job.len        = '0;
        job.marker     = 1'b0;
        job.seq        = seq_reg;
        job.channel    = word.unit_first ? word.channel : ch_reg;
        job.timestamp  = word.unit_first ? word.timestamp : ts_reg;
        job.extra0     = '0;
        job.extra1     = '0;
        job.data_byte  = word.data_byte;
        job.packet_end = 1'b0;
        job.unit_done  = 1'b0;

        if (word.unit_first)
        begin
            // new unit abandons whatever was in progress
            ch_next       = word.channel;
            ts_next       = word.timestamp;
            fe_next       = word.frame_end;
            frag_next     = starts_frag;
            pkt_left_next = '0;
            left_next     = size_eff - SIZE_W'(1);
            if (starts_frag)
            begin
                // nal header is held back for the fu indicator and header
                nal_next     = word.data_byte;
                pending_next = 1'b1;
            end
            else
            begin
                pending_next   = 1'b0;
                job_valid      = 1'b1;
                job.hdr        = word.unit_kind ? HDR_AUDIO : HDR_VIDEO;
                job.len        = size_eff[15:0] +
                                 (word.unit_kind ? LEN_OFS_AUDIO : LEN_OFS_VIDEO);
                job.marker     = word.unit_kind | word.frame_end;
                seq_next       = seq_reg + 16'd1;
                job.extra0     = size_eff[12:5];
                job.extra1     = {size_eff[4:0], 3'b000};
                job.unit_done  = (left_next == '0);
                job.packet_end = (left_next == '0);
            end
        end
        else if (left_reg != '0)
        begin
            job_valid = 1'b1;
            if (new_pkt)
            begin
                // fragment boundary: fu-a header ahead of this byte
                job.hdr      = HDR_FU;
                job.len      = {{(16 - PKT_W){1'b0}}, frag_len} + LEN_OFS_FU;
                job.marker   = last_frag & fe_reg;
                seq_next     = seq_reg + 16'd1;
                job.extra0   = {nal_reg[7:5], FU_A_TYPE};
                job.extra1   = {pending_reg, last_frag, 1'b0, nal_reg[4:0]};
                pending_next = 1'b0;
                pkt_cur      = frag_len;
            end
            left_next = left_reg - SIZE_W'(1);
            if (frag_reg)
            begin
                pkt_left_next = pkt_cur - PKT_W'(1);
            end
            job.unit_done  = (left_next == '0);
            job.packet_end = frag_reg ? (pkt_left_next == '0) : (left_next == '0);
        end
    end

    // unit state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= '0;
            left_reg     <= '0;
            pkt_left_reg <= '0;
            nal_reg      <= '0;
            pending_reg  <= 1'b0;
            ch_reg       <= '0;
            ts_reg       <= '0;
            fe_reg       <= 1'b0;
            frag_reg     <= 1'b0;
        end
        else if (accept)
        begin
            seq_reg      <= seq_next;
            left_reg     <= left_next;
            pkt_left_reg <= pkt_left_next;
            nal_reg      <= nal_next;
            pending_reg  <= pending_next;
            ch_reg       <= ch_next;
            ts_reg       <= ts_next;
            fe_reg       <= fe_next;
            frag_reg     <= frag_next;
        end
    end

endmodule

// File: hw/rtl/rtpilp_queue.sv
// small job queue between the front and back ends
module rtpilp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rtpilp_pkg::job_t  push_job,
    input  logic              pop,
    output rtpilp_pkg::job_t  head_job,
    output logic              full,
    output logic              empty
);
    import rtpilp_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head_job = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);

    // occupancy
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/rtpilp_back.sv
// back end: walks each job out as header, extra and data words
module rtpilp_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rtpilp_pkg::cfg_t          cfg,
    input  rtpilp_pkg::job_t          head_job,
    input  logic                      head_valid,
    output logic                      job_pop,
    output rtpilp_pkg::result_word_t  result_word,
    output logic                      empty,
    input  logic                      pop
);
    import rtpilp_pkg::*;

    // byte positions within one job
    localparam logic [4:0] STEP_FIRST    = 5'd0;
    localparam logic [4:0] STEP_HDR_LAST = 5'd15;
    localparam logic [4:0] STEP_EXT0     = 5'd18;
    localparam logic [4:0] STEP_DATA     = 5'd20;

    localparam logic [7:0] DOLLAR_BYTE = 8'h24;
    localparam logic [7:0] AU_HDR0     = 8'h00;
    localparam logic [7:0] AU_HDR1     = 8'h10;

    logic [4:0]   step_reg, step_next;
    logic         started_reg, started_next;
    result_word_t out_word_reg, out_word_next;
    logic         out_valid_reg;

    logic [4:0] step_cur;
    logic       load;

    assign step_cur    = started_reg ? step_reg
                       : ((head_job.hdr == HDR_NONE) ? STEP_DATA : STEP_FIRST);
    assign load        = head_valid && (!out_valid_reg || pop);
    assign job_pop     = load && (step_cur == STEP_DATA);
    assign result_word = out_word_reg;
    assign empty       = !out_valid_reg;

    // next position within the job
    always_comb
    begin
        if (step_cur == STEP_HDR_LAST && head_job.hdr == HDR_FU)
        begin
            step_next = STEP_EXT0;
        end
        else if (step_cur == STEP_HDR_LAST && head_job.hdr == HDR_VIDEO)
        begin
            step_next = STEP_DATA;
        end
        else
        begin
            step_next = step_cur + 5'd1;
        end
        started_next = (step_cur != STEP_DATA);
    end

    // word for the current position
    always_comb
    begin
        out_word_next.packet_end = 1'b0;
        out_word_next.unit_done  = 1'b0;
        out_word_next.run_last   = 1'b0;
        case (step_cur)
            5'd0:    out_word_next.out_byte = DOLLAR_BYTE;
            5'd1:    out_word_next.out_byte = head_job.channel;
            5'd2:    out_word_next.out_byte = head_job.len[15:8];
            5'd3:    out_word_next.out_byte = head_job.len[7:0];
            5'd4:    out_word_next.out_byte = {cfg.rtp_version, cfg.padding_bit,
                                               cfg.extension_bit, cfg.csrc_count};
            5'd5:    out_word_next.out_byte = {head_job.marker, cfg.payload_type};
            5'd6:    out_word_next.out_byte = head_job.seq[15:8];
            5'd7:    out_word_next.out_byte = head_job.seq[7:0];
            5'd8:    out_word_next.out_byte = head_job.timestamp[31:24];
            5'd9:    out_word_next.out_byte = head_job.timestamp[23:16];
            5'd10:   out_word_next.out_byte = head_job.timestamp[15:8];
            5'd11:   out_word_next.out_byte = head_job.timestamp[7:0];
            5'd12:   out_word_next.out_byte = cfg.source_id[31:24];
            5'd13:   out_word_next.out_byte = cfg.source_id[23:16];
            5'd14:   out_word_next.out_byte = cfg.source_id[15:8];
            5'd15:   out_word_next.out_byte = cfg.source_id[7:0];
            5'd16:   out_word_next.out_byte = AU_HDR0;
            5'd17:   out_word_next.out_byte = AU_HDR1;
            5'd18:   out_word_next.out_byte = head_job.extra0;
            5'd19:   out_word_next.out_byte = head_job.extra1;
            5'd20:
            begin
                out_word_next.out_byte   = head_job.data_byte;
                out_word_next.packet_end = head_job.packet_end;
                out_word_next.unit_done  = head_job.unit_done;
                out_word_next.run_last   = 1'b1;
            end
            default: out_word_next.out_byte = '0;
        endcase
    end

    // sequencer position and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg    <= step_next;
                started_reg <= started_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

// File: hw/rtl/rtp_interleaved_packetizer.sv
// top level of the rtsp interleaved rtp packetizer
//
// input channel: one media byte per word, push while full is low. the first
// byte of a unit carries unit_first, unit_size, unit_kind, frame_end, channel
// and timestamp. result channel: one stream byte per word, taken with pop
// while empty is low; packet_end, unit_done and run_last flag the last byte
// of a packet, of a unit and of the words caused by one input byte.
// the words for an input byte pass through the job queue and the result
// register. throughput: one payload byte per cycle while pop keeps up. a byte
// that opens a packet yields 17 words (video), 19 (fu-a fragment) or 21
// (audio) from the back end byte sequencer, which emits one word per cycle
// while pop keeps up; the four-entry job queue absorbs the difference, and
// full rises once all four entries hold jobs. the nal header of a fragmented
// unit and bytes outside a unit produce no words. stalling pop holds the
// result register and backs up into the queue and then full. reset clears
// the sequence number, unit state and queue, and loads the register defaults
// (version 2, payload type 96). the apb port takes writes at byte address
// 4*i; it is to be written only while idle, which the block does not enforce.
`include "rtp_interleaved_packetizer_assert.svh"

module rtp_interleaved_packetizer
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  rtpilp_pkg::unit_word_t    unit_word,
    output logic                      empty,
    input  logic                      pop,
    output rtpilp_pkg::result_word_t  result_word,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import rtpilp_pkg::*;

    cfg_t cfg_reg;
    logic cfg_write;
    logic accept;
    logic job_valid;
    job_t front_job;
    job_t head_job;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign full      = q_full;
    assign accept    = push && !q_full;
    assign q_push    = accept && job_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rtp_version   <= 2'd2;
            cfg_reg.padding_bit   <= 1'b0;
            cfg_reg.extension_bit <= 1'b0;
            cfg_reg.csrc_count    <= 4'd0;
            cfg_reg.payload_type  <= 7'd96;
            cfg_reg.source_id     <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_VERSION:   cfg_reg.rtp_version   <= pwdata[1:0];
                REG_PADDING:   cfg_reg.padding_bit   <= pwdata[0];
                REG_EXTENSION: cfg_reg.extension_bit <= pwdata[0];
                REG_CSRC:      cfg_reg.csrc_count    <= pwdata[3:0];
                REG_PTYPE:     cfg_reg.payload_type  <= pwdata[6:0];
                REG_SSRC:      cfg_reg.source_id     <= pwdata;
                default:       cfg_reg.source_id     <= cfg_reg.source_id;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[4:2])
            REG_VERSION:   prdata = {30'd0, cfg_reg.rtp_version};
            REG_PADDING:   prdata = {31'd0, cfg_reg.padding_bit};
            REG_EXTENSION: prdata = {31'd0, cfg_reg.extension_bit};
            REG_CSRC:      prdata = {28'd0, cfg_reg.csrc_count};
            REG_PTYPE:     prdata = {25'd0, cfg_reg.payload_type};
            REG_SSRC:      prdata = cfg_reg.source_id;
            default:       prdata = 32'd0;
        endcase
    end

    // front end
    rtpilp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (unit_word),
        .job_valid (job_valid),
        .job       (front_job)
    );

    // job queue
    rtpilp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back end
    rtpilp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_job    (head_job),
        .head_valid  (!q_empty),
        .job_pop     (q_pop),
        .result_word (result_word),
        .empty       (empty),
        .pop         (pop)
    );

    // queue never overruns or underruns
    `RTPILP_ASSERT_IMP(a_no_push_full, q_push, !q_full)
    `RTPILP_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty)
    // a unit always closes on a packet boundary
    `RTPILP_ASSERT_IMP(a_done_ends_pkt, !empty && result_word.unit_done,
        result_word.packet_end && result_word.run_last)
    // a job leaving the queue frees a slot for the front end
    `RTPILP_ASSERT_NXT(a_pop_frees_slot, q_pop && !q_push, !q_full)

endmodule
